// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the index generator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, masked while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/msig_pkg.sv =====
// ----------------------------------------------------------------------------
// msig_pkg
// Types, constants and register codes of the moveout sparse index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package msig_pkg;

  // Grid limits.
  localparam int MAX_SAMPLES    = 4096;
  localparam int MAX_TRACES     = 1024;
  localparam int MAX_VELOCITIES = 1024;

  // Field widths.
  localparam int TIME_W  = 12;
  localparam int TRACE_W = 10;
  localparam int VEL_W   = 10;
  localparam int P_W     = 32;
  localparam int V2_W    = 32;
  localparam int NT_W    = 13;
  localparam int IDX_W   = 16;
  localparam int SLOT_W  = 24;
  localparam int COS_W   = 17;
  localparam int RAD_W   = 34;

  // Stream payload widths.
  localparam int S_DATA_W = TIME_W + TRACE_W + VEL_W + P_W + V2_W;
  localparam int M_DATA_W = IDX_W + IDX_W + SLOT_W;

  // Square root: one result bit per iteration.
  localparam int SQRT_STEPS = 17;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

  // Fixed-point constants.
  localparam logic [RAD_W-1:0] RAD_ONE    = RAD_W'(64'd1 << 32);
  localparam logic [29:0]      ROUND_HALF = 30'd32768;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [0:0] REG_CUTOFF       = 1'b1;
  localparam logic [NT_W-1:0] SAMPLE_COUNT_RST = 13'd1024;
  localparam logic [31:0]     CUTOFF_RST       = 32'hFD70_A3D7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic mul_sq;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic check;
    logic sqrt_step;
    logic scale;
    logic index;
    logic load_out;
  } msig_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_last;
    logic out_free;
  } msig_stat_t;

endpackage

`default_nettype wire

// ===== hdl/moveout_sparse_index_generator.sv =====
// ----------------------------------------------------------------------------
// moveout_sparse_index_generator
// Sparse index generator for an elliptical moveout operator.
// ----------------------------------------------------------------------------
// Each input transaction describes one grid point. The block forms the squared
// sine p*p*v2 in Q0.32 and, if it lies below the cutoff register, the delayed
// sample time*sqrt(1 - s) rounded half up; if that sample lies inside the
// trace, the result transaction carries a valid index pair and its slot in the
// entry counter, otherwise a zero pair and the count so far. Exactly one
// result leaves for each input. Items are processed one at a time: an item
// passes through three multiply steps, a sum and a compare step, 17 iterations
// of the bit-serial square root, a scale, an index and an output load step,
// which waits for a free output register, before the next item is accepted;
// the square-root loop sets the rate. A finished result waits in the output
// register while the next item is processed. The user must write configuration
// registers via the APB port only while the block is idle; it does not enforce it.
`default_nettype none

module moveout_sparse_index_generator (
  input  wire                                clk,
  input  wire                                rst,
  // Input stream.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: time_index, trace_index, velocity_index, slowness,
  // squared_velocity.
  input  wire  [msig_pkg::S_DATA_W-1:0]      s_axis_tdata,
  // tuser: first.
  input  wire                                s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata: data_index, model_index, entry_slot.
  output logic [msig_pkg::M_DATA_W-1:0]      m_axis_tdata,
  // tuser: valid_res.
  output logic                               m_axis_tuser,
  // Configuration port.
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [msig_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire  [msig_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [msig_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import msig_pkg::*;

  msig_cmd_t cmd;
  msig_stat_t stat;

  logic [NT_W-1:0] sample_count;
  logic [31:0]     cutoff;
  logic [0:0]      reg_sel;
  logic            cfg_write;

  logic              res_valid;
  logic [IDX_W-1:0]  res_data_index;
  logic [IDX_W-1:0]  res_model_index;
  logic [SLOT_W-1:0] res_entry_slot;

  // Register decode: registers lie on word boundaries.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_COUNT_RST;
      cutoff       <= CUTOFF_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SAMPLE_COUNT: sample_count <= pwdata[NT_W-1:0];
        REG_CUTOFF:       cutoff       <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_sel)
      REG_SAMPLE_COUNT: prdata = APB_DATA_W'(sample_count);
      REG_CUTOFF:       prdata = cutoff;
      default:          prdata = '0;
    endcase
  end

  msig_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  msig_dpath u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .sample_count        (sample_count),
    .cutoff              (cutoff),
    .in_first            (s_axis_tuser),
    .in_time_index       (s_axis_tdata[11:0]),
    .in_trace_index      (s_axis_tdata[21:12]),
    .in_velocity_index   (s_axis_tdata[31:22]),
    .in_slowness         (s_axis_tdata[63:32]),
    .in_squared_velocity (s_axis_tdata[95:64]),
    .out_ready           (m_axis_tready),
    .out_valid           (m_axis_tvalid),
    .out_valid_res       (res_valid),
    .out_data_index      (res_data_index),
    .out_model_index     (res_model_index),
    .out_entry_slot      (res_entry_slot)
  );

  assign m_axis_tuser = res_valid;
  assign m_axis_tdata = {res_entry_slot, res_model_index, res_data_index};

endmodule

`default_nettype wire

// ===== hdl/msig_ctrl.sv =====
// ----------------------------------------------------------------------------
// msig_ctrl
// Sequencer that walks one item through the datapath step by step.
// ----------------------------------------------------------------------------
`default_nettype none

module msig_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  msig_pkg::msig_stat_t stat,
  output msig_pkg::msig_cmd_t  cmd
);
  import msig_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MUL_SQ = 10'b00_0000_0010,
    ST_MUL_LO = 10'b00_0000_0100,
    ST_MUL_HI = 10'b00_0000_1000,
    ST_SUM    = 10'b00_0001_0000,
    ST_CHECK  = 10'b00_0010_0000,
    ST_SQRT   = 10'b00_0100_0000,
    ST_SCALE  = 10'b00_1000_0000,
    ST_INDEX  = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_INDEX;
      end
      ST_INDEX: begin
        cmd.index  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msig_dpath.sv =====
// ----------------------------------------------------------------------------
// msig_dpath
// Multipliers, square-root unit, index arithmetic, entry counter and the
// output register of the index generator.
// ----------------------------------------------------------------------------
`default_nettype none

module msig_dpath (
  input  wire                              clk,
  input  wire                              rst,
  input  msig_pkg::msig_cmd_t              cmd,
  output msig_pkg::msig_stat_t             stat,
  input  wire  [msig_pkg::NT_W-1:0]        sample_count,
  input  wire  [31:0]                      cutoff,
  input  wire                              in_first,
  input  wire  [msig_pkg::TIME_W-1:0]      in_time_index,
  input  wire  [msig_pkg::TRACE_W-1:0]     in_trace_index,
  input  wire  [msig_pkg::VEL_W-1:0]       in_velocity_index,
  input  wire  [msig_pkg::P_W-1:0]         in_slowness,
  input  wire  [msig_pkg::V2_W-1:0]        in_squared_velocity,
  input  wire                              out_ready,
  output logic                             out_valid,
  output logic                             out_valid_res,
  output logic [msig_pkg::IDX_W-1:0]       out_data_index,
  output logic [msig_pkg::IDX_W-1:0]       out_model_index,
  output logic [msig_pkg::SLOT_W-1:0]      out_entry_slot
);
  import msig_pkg::*;

  // Captured item.
  logic               first;
  logic [TIME_W-1:0]  tim;
  logic [TRACE_W-1:0] trc;
  logic [VEL_W-1:0]   vel;
  logic [P_W-1:0]     slw;
  logic [V2_W-1:0]    v2;

  // Squared sine pipeline.
  logic [63:0] m2;
  logic [31:0] b_hi;
  logic [63:0] a_prod;
  logic [31:0] sine2;
  logic        pass;

  // Square root.
  logic [RAD_W-1:0]      rad;
  logic [18:0]           rem;
  logic [COS_W-1:0]      root;
  logic [SQRT_CNT_W-1:0] sqrt_cnt;

  // Index results.
  logic [NT_W-1:0]   smp;
  logic [IDX_W-1:0]  model_idx;
  logic [IDX_W-1:0]  data_idx;
  logic              valid_calc;
  logic [SLOT_W-1:0] entry_count;

  // Combinational helpers.
  logic [NT_W-1:0]   nt;
  logic [31:0]       mag;
  logic [63:0]       lo_prod;
  logic [63:0]       sum_full;
  logic              in_range;
  logic [20:0]       sq_cand;
  logic [20:0]       sq_trial;
  logic [29:0]       scaled;
  logic [23:0]       model_full;
  logic [23:0]       data_full;
  logic [SLOT_W-1:0] slot;

  // Sample count limited to the largest trace length.
  assign nt = (17'(sample_count) > 17'(MAX_SAMPLES)) ? NT_W'(MAX_SAMPLES) : sample_count;

  // Magnitude of the slowness; the most negative code maps to 2^31.
  assign mag = slw[P_W-1] ? (32'd0 - slw) : slw;

  assign lo_prod  = 64'(m2[31:0]) * 64'(v2);
  assign sum_full = a_prod + 64'(b_hi);
  assign in_range = (17'(trc) < 17'(MAX_TRACES)) && (17'(vel) < 17'(MAX_VELOCITIES));

  // One restoring square-root step: two radicand bits in, one root bit out.
  assign sq_cand  = {rem, rad[RAD_W-1 -: 2]};
  assign sq_trial = 21'({root, 2'b01});

  assign scaled     = 30'(tim) * 30'(root) + ROUND_HALF;
  assign model_full = 24'(vel) * 24'(nt) + 24'(tim);
  assign data_full  = 24'(trc) * 24'(nt) + 24'(smp);

  assign slot = first ? '0 : entry_count;

  assign stat.sqrt_last = (sqrt_cnt == SQRT_CNT_W'(1));
  assign stat.out_free  = !out_valid || out_ready;

  // Item capture and arithmetic steps.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      first <= in_first;
      tim   <= in_time_index;
      trc   <= in_trace_index;
      vel   <= in_velocity_index;
      slw   <= in_slowness;
      v2    <= in_squared_velocity;
    end
    if (cmd.mul_sq) begin
      m2 <= 64'(mag) * 64'(mag);
    end
    if (cmd.mul_lo) begin
      b_hi <= lo_prod[63:32];
    end
    if (cmd.mul_hi) begin
      a_prod <= 64'(m2[63:32]) * 64'(v2);
    end
    if (cmd.sum) begin
      // Q0.32 result saturates at its largest code, just below one.
      sine2     <= (|sum_full[63:48]) ? 32'hFFFF_FFFF : sum_full[47:16];
      model_idx <= model_full[IDX_W-1:0];
    end
    if (cmd.check) begin
      pass <= in_range && (sine2 < cutoff);
      rad  <= RAD_ONE - RAD_W'(sine2);
      rem  <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (sq_cand >= sq_trial) begin
        rem  <= 19'(sq_cand - sq_trial);
        root <= {root[COS_W-2:0], 1'b1};
      end else begin
        rem  <= sq_cand[18:0];
        root <= {root[COS_W-2:0], 1'b0};
      end
    end
    if (cmd.scale) begin
      smp <= scaled[28:16];
    end
    if (cmd.index) begin
      valid_calc <= pass && (smp < nt);
      data_idx   <= data_full[IDX_W-1:0];
    end
    if (cmd.load_out) begin
      out_valid_res   <= valid_calc;
      out_data_index  <= valid_calc ? data_idx : '0;
      out_model_index <= valid_calc ? model_idx : '0;
      out_entry_slot  <= slot;
    end
  end

  // Iteration counter of the square-root unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      sqrt_cnt <= '0;
    end else if (cmd.check) begin
      sqrt_cnt <= SQRT_CNT_W'(SQRT_STEPS);
    end else if (cmd.sqrt_step) begin
      sqrt_cnt <= sqrt_cnt - SQRT_CNT_W'(1);
    end
  end

  // Entry counter; a first item restarts it before its own slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.load_out) begin
      entry_count <= slot + SLOT_W'(valid_calc);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msig_checker.sv =====
// ----------------------------------------------------------------------------
// msig_checker
// Port-level assertions for the moveout sparse index generator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msig_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           s_axis_tvalid,
  input wire                           s_axis_tready,
  input wire                           m_axis_tvalid,
  input wire                           m_axis_tready,
  input wire [msig_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input wire                           m_axis_tuser
);
  import msig_pkg::*;

  // After reset the block is idle with no result pending.
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!m_axis_tvalid && s_axis_tready), "not idle after reset")

  // An accepted item keeps the block busy in the following cycle.
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while busy")

  // A result without an index pair carries zero indices.
  `ASSERT_CLK(a_invalid_zero, clk, rst, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[2*IDX_W-1:0] == '0), "nonzero indices on empty result")

  // A stalled result keeps its payload.
  `ASSERT_CLK(a_out_hold, clk, rst, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind moveout_sparse_index_generator msig_checker u_msig_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
